// ----- hdl/vfhp_pkg.sv -----
// Shared types and constants of the varint frame header parser.
package vfhp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned COUNT_W = 3;

  localparam logic [DATA_W-1:0] MASK_RESET = 32'h0000_0040;
  localparam logic REG_MASK = 1'b0;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  localparam logic [1:0] PHASE_TYPE = 2'd0;
  localparam logic [1:0] PHASE_TICK = 2'd1;
  localparam logic [1:0] PHASE_SIZE = 2'd2;
  localparam logic [1:0] PHASE_SKIP = 2'd3;

  localparam logic [COUNT_W-1:0] LAST_BYTE = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] message_type;
    logic is_compressed;
    logic [DATA_W-1:0] tick_value;
    logic [DATA_W-1:0] payload_length;
    logic [1:0] status;
  } record_t;

endpackage

// ----- hdl/vfhp_regs.sv -----
// Configuration register file with the compressed flag mask.
module vfhp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vfhp_pkg::ADDR_W-1:0]  paddr,
  input  logic [vfhp_pkg::DATA_W-1:0]  pwdata,
  output logic [vfhp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [vfhp_pkg::DATA_W-1:0]  flag_mask
);
  import vfhp_pkg::*;

  logic reg_write;

  assign pready = 1'b1;
  assign reg_write = psel && penable && pwrite && (paddr[2] == REG_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_mask <= MASK_RESET;
    end else if (reg_write) begin
      flag_mask <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_MASK) ? flag_mask : '0;

endmodule

// ----- hdl/vfhp_core.sv -----
// Varint decode state and next-record logic for one stream byte.
module vfhp_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [7:0]                   cur_byte,
  input  logic                         cur_eod,
  input  logic [vfhp_pkg::DATA_W-1:0]  flag_mask,
  output logic                         res_valid,
  output vfhp_pkg::record_t            res
);
  import vfhp_pkg::*;

  logic [1:0]         field_phase;
  logic [DATA_W-1:0]  varint_accumulator;
  logic [COUNT_W-1:0] varint_byte_count;
  logic [DATA_W-1:0]  held_type;
  logic [DATA_W-1:0]  held_tick;
  logic [DATA_W-1:0]  payload_remaining;

  logic [1:0]         field_phase_next;
  logic [DATA_W-1:0]  varint_accumulator_next;
  logic [COUNT_W-1:0] varint_byte_count_next;
  logic [DATA_W-1:0]  held_type_next;
  logic [DATA_W-1:0]  held_tick_next;
  logic [DATA_W-1:0]  payload_remaining_next;

  logic [COUNT_W-1:0] n;
  logic [DATA_W-1:0]  shifted;
  logic [DATA_W-1:0]  acc_or;
  logic               done;
  logic [DATA_W-1:0]  rec_type;
  logic [DATA_W-1:0]  rec_tick;
  logic [DATA_W-1:0]  rec_len;
  logic [1:0]         rec_status;

  always_comb begin
    n = (varint_byte_count > LAST_BYTE) ? LAST_BYTE : varint_byte_count;
    case (n)
      3'd0: shifted = {25'd0, cur_byte[6:0]};
      3'd1: shifted = {18'd0, cur_byte[6:0], 7'd0};
      3'd2: shifted = {11'd0, cur_byte[6:0], 14'd0};
      3'd3: shifted = {4'd0, cur_byte[6:0], 21'd0};
      default: shifted = {cur_byte[3:0], 28'd0};
    endcase
    acc_or = varint_accumulator | shifted;
  end

  always_comb begin
    field_phase_next = field_phase;
    varint_accumulator_next = varint_accumulator;
    varint_byte_count_next = varint_byte_count;
    held_type_next = held_type;
    held_tick_next = held_tick;
    payload_remaining_next = payload_remaining;
    res_valid = 1'b0;
    done = 1'b0;
    rec_type = '0;
    rec_tick = '0;
    rec_len = '0;
    rec_status = STATUS_OK;

    if (field_phase == PHASE_SKIP) begin
      if (payload_remaining > 32'd1) begin
        payload_remaining_next = payload_remaining - 32'd1;
      end else begin
        field_phase_next = PHASE_TYPE;
        payload_remaining_next = '0;
        held_type_next = '0;
        held_tick_next = '0;
        varint_accumulator_next = '0;
        varint_byte_count_next = '0;
      end
    end else if (cur_byte[7]) begin
      if (n == LAST_BYTE) begin
        res_valid = 1'b1;
        done = 1'b1;
        rec_status = STATUS_TOO_LONG;
        field_phase_next = PHASE_TYPE;
        varint_accumulator_next = '0;
        varint_byte_count_next = '0;
        held_type_next = '0;
        held_tick_next = '0;
        payload_remaining_next = '0;
      end else begin
        varint_accumulator_next = acc_or;
        varint_byte_count_next = n + 3'd1;
      end
    end else begin
      varint_accumulator_next = '0;
      varint_byte_count_next = '0;
      case (field_phase)
        PHASE_TYPE: begin
          held_type_next = acc_or;
          field_phase_next = PHASE_TICK;
        end
        PHASE_TICK: begin
          held_tick_next = acc_or;
          field_phase_next = PHASE_SIZE;
        end
        default: begin
          res_valid = 1'b1;
          done = 1'b1;
          rec_type = held_type;
          rec_tick = held_tick;
          rec_len = acc_or;
          rec_status = (acc_or != '0 && cur_eod) ? STATUS_TRUNCATED : STATUS_OK;
          held_type_next = '0;
          held_tick_next = '0;
          if (acc_or == '0 || cur_eod) begin
            field_phase_next = PHASE_TYPE;
            payload_remaining_next = '0;
          end else begin
            field_phase_next = PHASE_SKIP;
            payload_remaining_next = acc_or;
          end
        end
      endcase
    end

    if (!done && cur_eod &&
        (field_phase_next != PHASE_TYPE || varint_byte_count_next != '0)) begin
      res_valid = 1'b1;
      rec_type = (field_phase_next == PHASE_SKIP) ? '0 : held_type_next;
      rec_tick = (field_phase_next == PHASE_SKIP) ? '0 : held_tick_next;
      rec_len = payload_remaining_next;
      rec_status = STATUS_TRUNCATED;
      field_phase_next = PHASE_TYPE;
      varint_accumulator_next = '0;
      varint_byte_count_next = '0;
      held_type_next = '0;
      held_tick_next = '0;
      payload_remaining_next = '0;
    end
  end

  always_comb begin
    res.message_type = rec_type & ~flag_mask;
    res.is_compressed = |(rec_type & flag_mask);
    res.tick_value = rec_tick;
    res.payload_length = rec_len;
    res.status = rec_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_phase <= PHASE_TYPE;
      varint_accumulator <= '0;
      varint_byte_count <= '0;
      held_type <= '0;
      held_tick <= '0;
      payload_remaining <= '0;
    end else if (advance) begin
      field_phase <= field_phase_next;
      varint_accumulator <= varint_accumulator_next;
      varint_byte_count <= varint_byte_count_next;
      held_type <= held_type_next;
      held_tick <= held_tick_next;
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

// ----- hdl/vfhp_out_reg.sv -----
// Result register that holds one record until the consumer takes it.
module vfhp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  vfhp_pkg::record_t  rec_in,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               slot_free,
  output vfhp_pkg::record_t  rec_out
);
  import vfhp_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_out <= rec_in;
    end
  end

endmodule

// ----- hdl/varint_frame_header_parser.sv -----
// Top level of the varint frame header parser.
// A byte request is registered on acceptance and decoded from that holding register.
// A record is loaded into the output register when the core advances on its last byte.
// One byte per cycle is sustained while no record waits for a full output register.
// A byte stalls only while its record waits for a full output register.
// Synchronous reset clears the frame state, both valid flags, and sets the mask to 64.
module varint_frame_header_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   stream_byte,
  input  logic                         end_of_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vfhp_pkg::DATA_W-1:0]  message_type,
  output logic                         is_compressed,
  output logic [vfhp_pkg::DATA_W-1:0]  tick_value,
  output logic [vfhp_pkg::DATA_W-1:0]  payload_length,
  output logic [1:0]                   status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vfhp_pkg::ADDR_W-1:0]  paddr,
  input  logic [vfhp_pkg::DATA_W-1:0]  pwdata,
  output logic [vfhp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import vfhp_pkg::*;

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              held_eod;
  logic [DATA_W-1:0] flag_mask;
  logic              res_valid;
  record_t           res;
  record_t           rec_out;
  logic              slot_free;
  logic              advance;

  assign advance = held_valid && (!res_valid || slot_free);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= stream_byte;
      held_eod <= end_of_data;
    end
  end

  vfhp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .flag_mask (flag_mask)
  );

  vfhp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cur_byte  (held_byte),
    .cur_eod   (held_eod),
    .flag_mask (flag_mask),
    .res_valid (res_valid),
    .res       (res)
  );

  vfhp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .rec_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .rec_out   (rec_out)
  );

  assign message_type = rec_out.message_type;
  assign is_compressed = rec_out.is_compressed;
  assign tick_value = rec_out.tick_value;
  assign payload_length = rec_out.payload_length;
  assign status = rec_out.status;

endmodule

// ----- bench/varint_frame_header_parser_tb.sv -----
// Self-checking testbench for the varint frame header parser.
module varint_frame_header_parser_tb;
  import vfhp_pkg::*;

  localparam logic [ADDR_W-1:0] MASK_ADDR = {REG_MASK, 2'b00};

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] stream_byte;
  logic end_of_data;
  logic out_valid;
  logic out_ready;
  logic [DATA_W-1:0] message_type;
  logic is_compressed;
  logic [DATA_W-1:0] tick_value;
  logic [DATA_W-1:0] payload_length;
  logic [1:0] status;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  varint_frame_header_parser dut (.*);

  record_t pending_records[$];
  int mismatches = 0;
  int sent_bytes = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  logic [31:0] flag_mask;
  logic [1:0] phase_q;
  logic [31:0] acc_q;
  logic [2:0] nbytes_q;
  logic [31:0] type_q;
  logic [31:0] tick_q;
  logic [31:0] remain_q;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void frame_clear();
    phase_q = PHASE_TYPE;
    acc_q = '0;
    nbytes_q = '0;
    type_q = '0;
    tick_q = '0;
    remain_q = '0;
  endfunction

  function automatic void post_record(input logic [31:0] t, input logic [31:0] k,
                                      input logic [31:0] len, input logic [1:0] st);
    record_t r;
    r.message_type = t & ~flag_mask;
    r.is_compressed = |(t & flag_mask);
    r.tick_value = k;
    r.payload_length = len;
    r.status = st;
    pending_records.push_back(r);
  endfunction

  task automatic decode_byte(input logic [7:0] value, input logic last);
    logic [2:0] n;
    logic [31:0] v;
    logic [31:0] t;
    logic [31:0] k;
    if (phase_q == PHASE_SKIP) begin
      if (remain_q > 1) remain_q = remain_q - 1;
      else frame_clear();
    end else begin
      n = (nbytes_q > LAST_BYTE) ? LAST_BYTE : nbytes_q;
      acc_q = acc_q | (32'(value[6:0]) << (7 * n));
      if (value[7]) begin
        if (n == LAST_BYTE) begin
          post_record('0, '0, '0, STATUS_TOO_LONG);
          frame_clear();
          return;
        end
        nbytes_q = n + 3'd1;
      end else begin
        v = acc_q;
        acc_q = '0;
        nbytes_q = '0;
        case (phase_q)
          PHASE_TYPE: begin
            type_q = v;
            phase_q = PHASE_TICK;
          end
          PHASE_TICK: begin
            tick_q = v;
            phase_q = PHASE_SIZE;
          end
          default: begin
            if (v != 0 && last) begin
              post_record(type_q, tick_q, v, STATUS_TRUNCATED);
              frame_clear();
              return;
            end
            post_record(type_q, tick_q, v, STATUS_OK);
            if (v == 0) begin
              frame_clear();
            end else begin
              type_q = '0;
              tick_q = '0;
              phase_q = PHASE_SKIP;
              remain_q = v;
            end
            return;
          end
        endcase
      end
    end
    if (last && (phase_q != PHASE_TYPE || nbytes_q != 0)) begin
      t = type_q;
      k = tick_q;
      if (phase_q == PHASE_SKIP) begin
        t = '0;
        k = '0;
      end
      post_record(t, k, remain_q, STATUS_TRUNCATED);
      frame_clear();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    record_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, got type %h tick %h len %h status %0d",
                 $time, message_type, tick_value, payload_length, status);
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        compare_field("message_type", want.message_type, message_type);
        compare_field("is_compressed", 32'(want.is_compressed), 32'(is_compressed));
        compare_field("tick_value", want.tick_value, tick_value);
        compare_field("payload_length", want.payload_length, payload_length);
        compare_field("status", 32'(want.status), 32'(status));
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      stream_byte <= 8'($urandom);
      end_of_data <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= value;
    end_of_data <= last;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    decode_byte(value, last);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && pending_records.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MASK_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    flag_mask = value;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MASK_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== flag_mask) begin
      $display("%0t: mask readback expected %h, got %h", $time, flag_mask, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic chance_eod();
    return $urandom_range(199) == 0;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(4))
      0: return 32'($urandom_range(127));
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [31:0] random_mask();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      3: return MASK_RESET;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_varint(input logic [31:0] value);
    int len;
    logic [7:0] b;
    len = 1;
    while (len < 5 && (value >> (7 * len)) != 0) len++;
    if ($urandom_range(9) == 0) len = $urandom_range(5, len);
    for (int i = 0; i < len; i++) begin
      b = 8'((value >> (7 * i)) & 32'h7F);
      if (i == 4 && $urandom_range(1) == 1) b[6:4] = 3'($urandom_range(7));
      b[7] = (i != len - 1);
      send_byte(b, chance_eod());
    end
  endtask

  task automatic resync();
    if (phase_q != PHASE_TYPE || nbytes_q != 0) send_byte(8'($urandom), 1'b1);
  endtask

  task automatic send_random_frame();
    logic [31:0] size_val;
    int pick;
    int n;
    resync();
    pick = $urandom_range(99);
    if (pick < 6) begin
      n = $urandom_range(6, 1);
      repeat (n) send_byte(8'($urandom), chance_eod());
    end else if (pick < 10) begin
      n = $urandom_range(2);
      if (n > 0) send_varint(random_value());
      if (n > 1) send_varint(random_value());
      repeat (5) send_byte(8'h80 | 8'($urandom_range(127)), 1'b0);
    end else begin
      send_varint(random_value());
      send_varint(random_value());
      if (pick < 92) size_val = $urandom_range(6);
      else if (pick < 96) size_val = $urandom_range(40);
      else size_val = random_value();
      send_varint(size_val);
      n = (size_val > 40) ? $urandom_range(3) : int'(size_val);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), chance_eod());
      // A huge size would skip for too long, so the stream ends inside the payload.
      if (size_val > 40) send_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic test_register_access();
    apb_read_check();
    apb_write(32'hFFFF_FFFF);
    apb_read_check();
    apb_write(32'h0);
    apb_read_check();
    apb_write(MASK_RESET);
    apb_read_check();
  endtask

  task automatic test_directed_frames();
    logic [8:0] script [26];
    script = '{9'h041, 9'h080, 9'h001, 9'h002, 9'h0AA, 9'h155,
               9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h000, 9'h000,
               9'h080, 9'h080, 9'h080, 9'h080, 9'h080,
               9'h185,
               9'h007, 9'h003, 9'h102,
               9'h001, 9'h001, 9'h002, 9'h100};
    foreach (script[i]) send_byte(script[i][7:0], script[i][8]);
    settle();
  endtask

  task automatic test_compressed_mask();
    logic [31:0] masks [5];
    masks = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, $urandom};
    foreach (masks[i]) begin
      apb_write(masks[i]);
      apb_read_check();
      repeat (8) send_random_frame();
      settle();
    end
    apb_write(MASK_RESET);
  endtask

  task automatic test_output_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    resync();
    hold_cycles = 300;
    repeat (40) begin
      send_byte(8'($urandom_range(127)), 1'b0);
      send_byte(8'($urandom_range(127)), 1'b0);
      send_byte(8'h00, 1'b0);
    end
    settle();
    send_idle_pct = saved_pct;
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct, input int budget);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = sent_bytes + budget;
    while (sent_bytes < target) begin
      if ($urandom_range(99) < 3) begin
        settle();
        apb_write(random_mask());
      end
      send_random_frame();
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    stream_byte = '0;
    end_of_data = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    flag_mask = MASK_RESET;
    frame_clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 63;
    test_register_access();
    test_directed_frames();
    test_compressed_mask();
    test_output_backpressure();
    test_random_stream(23, 63, 190);
    test_random_stream(63, 23, 190);
    test_random_stream(0, 0, 185);
    if (pending_records.size() != 0) begin
      $display("%0t: %0d expected records never arrived", $time, pending_records.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("%0t: run timed out", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
